@@ hdl/i2c_master_register_write_assert.svh @@
// Assertion macros used by the controller RTL file.
`ifndef I2C_MASTER_REGISTER_WRITE_ASSERT_SVH
`define I2C_MASTER_REGISTER_WRITE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define I2CMRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define I2CMRW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/i2cmrw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cmrw_pkg;

  localparam int unsigned PrefixWidth = 4;
  localparam logic [PrefixWidth-1:0] PrefixReset = 4'd4;

  localparam logic [1:0] STAGE_IDLE  = 2'd0;
  localparam logic [1:0] STAGE_START = 2'd1;
  localparam logic [1:0] STAGE_BYTES = 2'd2;
  localparam logic [1:0] STAGE_STOP  = 2'd3;

  localparam logic [3:0] ACK_SLOT  = 4'd8;
  localparam logic [1:0] LAST_BYTE = 2'd2;

  localparam logic [1:0] PHASE_SET_SDA  = 2'd0;
  localparam logic [1:0] PHASE_SCL_HIGH = 2'd1;
  localparam logic [1:0] PHASE_SAMPLE   = 2'd2;
  localparam logic [1:0] PHASE_SCL_LOW  = 2'd3;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

endpackage

`default_nettype wire

@@ hdl/i2c_master_register_write.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake               | Payload
// in_      | in_valid / in_ready     | cmd, device, reg_addr, wdata, sda_in
// out_     | out_valid / out_ready   | scl_release, sda_release, busy_res, done_res, nack
// cfg_     | cfg_valid / cfg_ready   | address_prefix
//
// Every accepted item yields one result item in the next cycle, from the output register.
// A new item is taken in every cycle while the output register is empty or being read.
// The whole transaction state advances in a single pass of logic per item.
// A synchronous active-low reset returns the controller to idle with both lines released.
// A stalled output holds its item and blocks input only while it is not taken.

module i2c_master_register_write (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [2:0] in_device,
  input  wire logic [7:0] in_reg_addr,
  input  wire logic [7:0] in_wdata,
  input  wire logic       in_sda_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_scl_release,
  output logic            out_sda_release,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic            out_nack,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [i2cmrw_pkg::PrefixWidth-1:0] cfg_address_prefix
);

  logic [i2cmrw_pkg::PrefixWidth-1:0] prefix_r;
  logic [1:0] stage_r,      stage_nxt;
  logic [1:0] phase_r,      phase_nxt;
  logic [3:0] bit_count_r,  bit_count_nxt;
  logic [1:0] byte_index_r, byte_index_nxt;
  logic [7:0] shift_r,      shift_nxt;
  logic [7:0] held_addr_r,  held_addr_nxt;
  logic [7:0] held_data_r,  held_data_nxt;
  logic       nack_r,       nack_nxt;
  logic       scl_r,        scl_nxt;
  logic       sda_r,        sda_nxt;
  logic       done_nxt;
  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_busy_r, out_done_r, out_nack_r;
  logic       in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    stage_nxt      = stage_r;
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    byte_index_nxt = byte_index_r;
    shift_nxt      = shift_r;
    held_addr_nxt  = held_addr_r;
    held_data_nxt  = held_data_r;
    nack_nxt       = nack_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    done_nxt       = 1'b0;
    if (in_cmd == i2cmrw_pkg::CMD_WRITE) begin
      if (stage_r == i2cmrw_pkg::STAGE_IDLE) begin
        shift_nxt      = {prefix_r, in_device, 1'b0};
        held_addr_nxt  = in_reg_addr;
        held_data_nxt  = in_wdata;
        nack_nxt       = 1'b0;
        phase_nxt      = i2cmrw_pkg::PHASE_SET_SDA;
        bit_count_nxt  = 4'd0;
        byte_index_nxt = 2'd0;
        stage_nxt      = i2cmrw_pkg::STAGE_START;
      end
    end else begin
      unique case (stage_r)
        i2cmrw_pkg::STAGE_IDLE: begin
        end
        i2cmrw_pkg::STAGE_START: begin
          if (phase_r == i2cmrw_pkg::PHASE_SET_SDA) begin
            sda_nxt   = 1'b0;
            phase_nxt = i2cmrw_pkg::PHASE_SCL_HIGH;
          end else begin
            scl_nxt        = 1'b0;
            phase_nxt      = i2cmrw_pkg::PHASE_SET_SDA;
            bit_count_nxt  = 4'd0;
            byte_index_nxt = 2'd0;
            stage_nxt      = i2cmrw_pkg::STAGE_BYTES;
          end
        end
        i2cmrw_pkg::STAGE_BYTES: begin
          phase_nxt = phase_r + 2'd1;
          if (bit_count_r < i2cmrw_pkg::ACK_SLOT) begin
            unique case (phase_r)
              i2cmrw_pkg::PHASE_SET_SDA:  sda_nxt = shift_r[7];
              i2cmrw_pkg::PHASE_SCL_HIGH: scl_nxt = 1'b1;
              i2cmrw_pkg::PHASE_SAMPLE: begin
              end
              i2cmrw_pkg::PHASE_SCL_LOW: begin
                scl_nxt       = 1'b0;
                shift_nxt     = {shift_r[6:0], 1'b0};
                bit_count_nxt = bit_count_r + 4'd1;
              end
              default: begin
              end
            endcase
          end else begin
            unique case (phase_r)
              i2cmrw_pkg::PHASE_SET_SDA:  sda_nxt = 1'b1;
              i2cmrw_pkg::PHASE_SCL_HIGH: scl_nxt = 1'b1;
              i2cmrw_pkg::PHASE_SAMPLE:   nack_nxt = nack_r | in_sda_in;
              i2cmrw_pkg::PHASE_SCL_LOW: begin
                scl_nxt       = 1'b0;
                bit_count_nxt = 4'd0;
                if (byte_index_r >= i2cmrw_pkg::LAST_BYTE) begin
                  byte_index_nxt = 2'd0;
                  stage_nxt      = i2cmrw_pkg::STAGE_STOP;
                end else begin
                  byte_index_nxt = byte_index_r + 2'd1;
                  shift_nxt      = (byte_index_r == 2'd0) ? held_addr_r : held_data_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
        i2cmrw_pkg::STAGE_STOP: begin
          if (phase_r == i2cmrw_pkg::PHASE_SET_SDA) begin
            sda_nxt   = 1'b0;
            phase_nxt = i2cmrw_pkg::PHASE_SCL_HIGH;
          end else if (phase_r == i2cmrw_pkg::PHASE_SCL_HIGH) begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cmrw_pkg::PHASE_SAMPLE;
          end else begin
            sda_nxt   = 1'b1;
            phase_nxt = i2cmrw_pkg::PHASE_SET_SDA;
            stage_nxt = i2cmrw_pkg::STAGE_IDLE;
            done_nxt  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= i2cmrw_pkg::PrefixReset;
      stage_r      <= i2cmrw_pkg::STAGE_IDLE;
      phase_r      <= 2'd0;
      bit_count_r  <= 4'd0;
      byte_index_r <= 2'd0;
      shift_r      <= 8'd0;
      held_addr_r  <= 8'd0;
      held_data_r  <= 8'd0;
      nack_r       <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prefix_r <= cfg_address_prefix;
      end
      if (in_fire) begin
        stage_r      <= stage_nxt;
        phase_r      <= phase_nxt;
        bit_count_r  <= bit_count_nxt;
        byte_index_r <= byte_index_nxt;
        shift_r      <= shift_nxt;
        held_addr_r  <= held_addr_nxt;
        held_data_r  <= held_data_nxt;
        nack_r       <= nack_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= sda_nxt;
      out_busy_r <= (stage_nxt != i2cmrw_pkg::STAGE_IDLE);
      out_done_r <= done_nxt;
      out_nack_r <= nack_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_release = out_scl_r;
  assign out_sda_release = out_sda_r;
  assign out_busy_res    = out_busy_r;
  assign out_done_res    = out_done_r;
  assign out_nack        = out_nack_r;

`include "i2c_master_register_write_assert.svh"

  `I2CMRW_ASSERT(a_bit_count_range, bit_count_r <= i2cmrw_pkg::ACK_SLOT, "bit count beyond ack slot")
  `I2CMRW_ASSERT(a_byte_index_range, byte_index_r <= i2cmrw_pkg::LAST_BYTE, "byte index beyond last byte")
  `I2CMRW_ASSERT(a_idle_released, (stage_r == i2cmrw_pkg::STAGE_IDLE) |-> (scl_r && sda_r), "lines held while idle")
  `I2CMRW_ASSERT(a_done_not_busy, (out_valid_r && out_done_r) |-> !out_busy_r, "done item still reports busy")
  `I2CMRW_ASSERT(a_stop_ends, (in_fire && !in_cmd && stage_r == i2cmrw_pkg::STAGE_STOP && phase_r == i2cmrw_pkg::PHASE_SAMPLE) |=> (stage_r == i2cmrw_pkg::STAGE_IDLE), "stop did not return to idle")

endmodule

`default_nettype wire
